// ----- hw/rtl/parallel_io_controller_top_macros.svh -----
// Assertion helpers shared by the RTL files that carry checks.
// All macros sample on clk and are held off while rst_n is low.
`ifndef PARALLEL_IO_CONTROLLER_TOP_MACROS_SVH
`define PARALLEL_IO_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define PIOC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PIOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pioc_pkg.sv -----
`timescale 1ns / 1ps

package pioc_pkg;

    typedef enum logic [2:0] {
        FUNC_READ   = 3'd0,
        FUNC_WRITE  = 3'd1,
        FUNC_CTRL   = 3'd2,
        FUNC_PIN    = 3'd3,
        FUNC_STROBE = 3'd4,
        FUNC_ACK    = 3'd5,
        FUNC_RETI   = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        MODE_OUT   = 2'd0,
        MODE_IN    = 2'd1,
        MODE_BIDIR = 2'd2,
        MODE_CTL   = 2'd3
    } mode_t;

    // low nibble of an odd control byte
    localparam logic [3:0] CTRL_IRQ_WORD = 4'h3;
    localparam logic [3:0] CTRL_IRQ_CTRL = 4'h7;
    localparam logic [3:0] CTRL_MODE     = 4'hf;

    // daisy-chain commands from the top level to one port
    typedef struct packed {
        logic ack_take;
        logic reti;
    } port_cmd_t;

    // per-access result of one port
    typedef struct packed {
        logic [7:0] read_data;
        logic       out_valid;
        logic [7:0] drv_data;
        logic [7:0] out_changed;
        logic       trig;
    } port_res_t;

    // interrupt status (current) and ready flag (after the access)
    typedef struct packed {
        logic       pending;
        logic       in_service;
        logic       irq_en;
        logic [7:0] vector;
        logic       ready;
    } port_stat_t;

endpackage

// ----- hw/rtl/pioc_port.sv -----
`timescale 1ns / 1ps

module pioc_port (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req,
    input  pioc_pkg::func_t        func,
    input  logic [7:0]             data_byte,
    input  logic [7:0]             pin_mask,
    input  logic                   pin_valid,
    input  pioc_pkg::port_cmd_t    cmd,
    output pioc_pkg::port_res_t    res,
    output pioc_pkg::port_stat_t   stat
);

    pioc_pkg::mode_t mode_reg, mode_next;
    logic [7:0] latch_reg, latch_next;
    logic [7:0] img_reg, img_next;
    logic       fn_reg, fn_next;
    logic [7:0] dir_reg, dir_next;
    logic [7:0] mask_inv_reg, mask_inv_next;
    logic       and_reg, and_next;
    logic       high_reg, high_next;
    logic       mask_pend_reg, mask_pend_next;
    logic       dir_pend_reg, dir_pend_next;
    logic [7:0] vector_reg, vector_next;
    logic       en_reg, en_next;
    logic       insvc_reg, insvc_next;
    logic       pend_reg, pend_next;
    logic       ready_reg, ready_next;
    logic       first_reg, first_next;

    logic            wr_req;
    logic [7:0]      wr_val;
    pioc_pkg::mode_t wr_mode;
    logic [7:0]      img_upd;
    logic [7:0]      masked;
    logic            fn_val;

    // pin function over the updated pin image
    assign img_upd = (img_reg & ~pin_mask) | (data_byte & pin_mask);
    assign masked  = img_upd & mask_inv_reg;
    assign fn_val  = and_reg ? (high_reg ? (masked == mask_inv_reg) : (masked == 8'h00))
                             : (high_reg ? (masked != 8'h00) : (masked != mask_inv_reg));

    always_comb
    begin
        mode_next      = mode_reg;
        latch_next     = latch_reg;
        img_next       = img_reg;
        fn_next        = fn_reg;
        dir_next       = dir_reg;
        mask_inv_next  = mask_inv_reg;
        and_next       = and_reg;
        high_next      = high_reg;
        mask_pend_next = mask_pend_reg;
        dir_pend_next  = dir_pend_reg;
        vector_next    = vector_reg;
        en_next        = en_reg;
        insvc_next     = insvc_reg;
        pend_next      = pend_reg;
        ready_next     = ready_reg;
        first_next     = first_reg;
        wr_req         = 1'b0;
        wr_val         = data_byte;
        wr_mode        = mode_reg;
        res            = '0;

        if (req)
        begin
            case (func)
                pioc_pkg::FUNC_READ:
                begin
                    if (mode_reg == pioc_pkg::MODE_CTL)
                    begin
                        if (pin_valid)
                        begin
                            img_next = data_byte;
                        end
                        res.read_data = (latch_reg & ~dir_reg) |
                                        ((pin_valid ? data_byte : img_reg) & dir_reg);
                    end
                    else
                    begin
                        res.read_data = pin_valid ? data_byte : latch_reg;
                    end
                end
                pioc_pkg::FUNC_WRITE:
                begin
                    wr_req = 1'b1;
                end
                pioc_pkg::FUNC_CTRL:
                begin
                    if (dir_pend_reg)
                    begin
                        dir_next      = data_byte;
                        dir_pend_next = 1'b0;
                    end
                    else if (mask_pend_reg)
                    begin
                        mask_inv_next  = ~data_byte;
                        mask_pend_next = 1'b0;
                    end
                    else if (!data_byte[0])
                    begin
                        vector_next = data_byte;
                    end
                    else
                    begin
                        case (data_byte[3:0])
                            pioc_pkg::CTRL_IRQ_WORD:
                            begin
                                en_next = data_byte[7];
                            end
                            pioc_pkg::CTRL_IRQ_CTRL:
                            begin
                                en_next   = data_byte[7];
                                and_next  = data_byte[6];
                                high_next = data_byte[5];
                                if (data_byte[4])
                                begin
                                    mask_pend_next = 1'b1;
                                end
                            end
                            pioc_pkg::CTRL_MODE:
                            begin
                                mode_next = pioc_pkg::mode_t'(data_byte[7:6]);
                                if (data_byte[7:6] == pioc_pkg::MODE_CTL)
                                begin
                                    dir_pend_next = 1'b1;
                                end
                                // leaving input mode re-drives the latch
                                if (mode_reg == pioc_pkg::MODE_IN)
                                begin
                                    wr_req  = 1'b1;
                                    wr_val  = latch_reg;
                                    wr_mode = pioc_pkg::mode_t'(data_byte[7:6]);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                pioc_pkg::FUNC_PIN:
                begin
                    img_next = img_upd;
                    fn_next  = fn_val;
                    if (!fn_reg && fn_val && en_reg)
                    begin
                        pend_next = 1'b1;
                        res.trig  = 1'b1;
                    end
                end
                pioc_pkg::FUNC_STROBE:
                begin
                    if (en_reg)
                    begin
                        pend_next = 1'b1;
                        res.trig  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (wr_req)
        begin
            latch_next = wr_val;
            if (wr_mode != pioc_pkg::MODE_IN)
            begin
                first_next      = 1'b0;
                ready_next      = 1'b1;
                res.out_valid   = 1'b1;
                res.drv_data    = wr_val;
                res.out_changed = (first_reg ? ~wr_val : latch_reg) ^ wr_val;
            end
        end

        if (cmd.ack_take)
        begin
            pend_next  = 1'b0;
            insvc_next = 1'b1;
        end
        if (cmd.reti)
        begin
            insvc_next = 1'b0;
        end
    end

    assign stat.pending    = pend_reg;
    assign stat.in_service = insvc_reg;
    assign stat.irq_en     = en_reg;
    assign stat.vector     = vector_reg;
    assign stat.ready      = ready_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= pioc_pkg::MODE_IN;
            latch_reg     <= 8'h00;
            img_reg       <= 8'hff;
            fn_reg        <= 1'b0;
            dir_reg       <= 8'h00;
            mask_inv_reg  <= 8'hff;
            and_reg       <= 1'b0;
            high_reg      <= 1'b0;
            mask_pend_reg <= 1'b0;
            dir_pend_reg  <= 1'b0;
            vector_reg    <= 8'h00;
            en_reg        <= 1'b0;
            insvc_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            ready_reg     <= 1'b1;
            first_reg     <= 1'b1;
        end
        else
        begin
            mode_reg      <= mode_next;
            latch_reg     <= latch_next;
            img_reg       <= img_next;
            fn_reg        <= fn_next;
            dir_reg       <= dir_next;
            mask_inv_reg  <= mask_inv_next;
            and_reg       <= and_next;
            high_reg      <= high_next;
            mask_pend_reg <= mask_pend_next;
            dir_pend_reg  <= dir_pend_next;
            vector_reg    <= vector_next;
            en_reg        <= en_next;
            insvc_reg     <= insvc_next;
            pend_reg      <= pend_next;
            ready_reg     <= ready_next;
            first_reg     <= first_next;
        end
    end

endmodule

// ----- hw/rtl/parallel_io_controller_top.sv -----
`timescale 1ns / 1ps
// The result is registered at the input transfer edge, into main or, while main is stalled, into skid.
// Throughput: one access per cycle while s_tready is high; all port state is read combinationally
// and updated at the same edge that registers the result.
// A two-entry output buffer (main plus skid) keeps s_tready high while one result waits.
// Reset (rst_n low, asynchronous): both ports return to byte input, interrupts off,
// ready flags high, IRQ line low; both output entries are emptied.

`include "parallel_io_controller_top_macros.svh"

module parallel_io_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] pin_mask
    input  logic [4:0]  s_tuser,   // [2:0] func, [3] port_sel, [4] pin_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [7:0] read_data, [8] ack_valid, [16:9] ack_vector,
                                   // [17] out_valid, [25:18] drv_data, [33:26] out_changed,
                                   // [34] irq_line, [35] ready_a, [36] ready_b, [39:37] zero
);

    // ---------------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------------
    logic            accept;
    pioc_pkg::func_t func;
    logic            port_sel;
    logic            pin_valid;
    logic [7:0]      data_byte;
    logic [7:0]      pin_mask;

    assign accept    = s_tvalid & s_tready;
    assign func      = pioc_pkg::func_t'(s_tuser[2:0]);
    assign port_sel  = s_tuser[3];
    assign pin_valid = s_tuser[4];
    assign data_byte = s_tdata[7:0];
    assign pin_mask  = s_tdata[15:8];

    // ---------------------------------------------------------------------
    // Ports and daisy chain. Port A always wins the acknowledge; port B is
    // only taken when A has nothing pending and is not in service.
    // ---------------------------------------------------------------------
    pioc_pkg::port_cmd_t  cmd_a, cmd_b;
    pioc_pkg::port_res_t  res_a, res_b, res_sel;
    pioc_pkg::port_stat_t stat_a, stat_b;
    logic                 is_ack;
    logic                 reti;
    logic                 take_a;
    logic                 take_b;

    assign is_ack = accept && (func == pioc_pkg::FUNC_ACK);
    assign reti   = accept && (func == pioc_pkg::FUNC_RETI);
    assign take_a = is_ack && stat_a.pending;
    assign take_b = is_ack && !stat_a.pending && !stat_a.in_service && stat_b.pending;

    assign cmd_a.ack_take = take_a;
    assign cmd_a.reti     = reti;
    assign cmd_b.ack_take = take_b;
    assign cmd_b.reti     = reti;

    pioc_port u_port_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (accept && !port_sel),
        .func      (func),
        .data_byte (data_byte),
        .pin_mask  (pin_mask),
        .pin_valid (pin_valid),
        .cmd       (cmd_a),
        .res       (res_a),
        .stat      (stat_a)
    );

    pioc_port u_port_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (accept && port_sel),
        .func      (func),
        .data_byte (data_byte),
        .pin_mask  (pin_mask),
        .pin_valid (pin_valid),
        .cmd       (cmd_b),
        .res       (res_b),
        .stat      (stat_b)
    );

    assign res_sel = port_sel ? res_b : res_a;

    // ---------------------------------------------------------------------
    // Shared IRQ line: set by a trigger, dropped by an acknowledge, re-raised
    // by reti when the highest pending port still has interrupts enabled.
    // ---------------------------------------------------------------------
    logic irq_line_reg, irq_line_next;

    always_comb
    begin
        irq_line_next = irq_line_reg;
        if (res_sel.trig)
        begin
            irq_line_next = 1'b1;
        end
        if (take_a || take_b)
        begin
            irq_line_next = 1'b0;
        end
        if (reti && (stat_a.pending ? stat_a.irq_en : (stat_b.pending && stat_b.irq_en)))
        begin
            irq_line_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_line_reg <= 1'b0;
        end
        else
        begin
            irq_line_reg <= irq_line_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result word
    // ---------------------------------------------------------------------
    logic [7:0]  ack_vector;
    logic [36:0] result;

    assign ack_vector = take_a ? stat_a.vector : (take_b ? stat_b.vector : 8'h00);

    assign result = {stat_b.ready, stat_a.ready, irq_line_next,
                     res_sel.out_changed, res_sel.drv_data, res_sel.out_valid,
                     ack_vector, (take_a || take_b), res_sel.read_data};

    // ---------------------------------------------------------------------
    // Output buffer: main entry drives the bus, skid entry catches one
    // transfer while main is stalled.
    // ---------------------------------------------------------------------
    logic [36:0] main_reg, main_next;
    logic [36:0] skid_reg, skid_next;
    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    logic        pop;

    assign pop = main_valid_reg && m_tready;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (accept)
        begin
            // skid is empty whenever a transfer is accepted
            if (!main_valid_reg || pop)
            begin
                main_next       = result;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {3'b000, main_reg};

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `PIOC_ASSERT_IMPL(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid full with main empty")
    `PIOC_ASSERT_NEXT(a_ack_drops_line, take_a || take_b, !irq_line_reg, "IRQ line held after acknowledge")
    `PIOC_ASSERT_NEXT(a_ack_b_in_service, take_b, stat_b.in_service && !stat_b.pending, "port B acknowledge not recorded")
    `PIOC_ASSERT_NEXT(a_reti_clears_service, reti, !stat_a.in_service && !stat_b.in_service, "in-service left set after reti")

endmodule

// ----- dv/tb_parallel_io_controller_top.sv -----
`timescale 1ns / 1ps

module tb_parallel_io_controller_top;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int N_DIR       = 28;     // directed table rows
    localparam int N_RAND      = 1400;   // random accesses after the table
    localparam int CALM_TX_LO  = 300;    // sender never idles for these accesses
    localparam int CALM_TX_HI  = 650;
    localparam int PAUSE_AT    = 1200;   // sender waits for a full drain here
    localparam int CALM_RX_LO  = 200;    // receiver always ready in these cycles
    localparam int CALM_RX_HI  = 500;
    localparam int HOLD_AT     = 700;    // receiver holds off from here until HOLD_AT + HOLD_LEN
    localparam int HOLD_LEN    = 400;
    localparam int STALL_LIMIT = 4000;   // cycles with no transfer on either side
    localparam int DRAIN_CYC   = 16;

    localparam logic       PORT_A    = 1'b0;
    localparam logic       PORT_B    = 1'b1;
    localparam logic [2:0] FUNC_RSVD = 3'd7;

    // One result, field by field
    typedef struct packed {
        logic [7:0] rd;
        logic       ackv;
        logic [7:0] vec;
        logic       ov;
        logic [7:0] od;
        logic [7:0] oc;
        logic       irq;
        logic       ra;
        logic       rb;
    } pio_res_t;

    // One directed access; typed rows carry their result written out by hand
    typedef struct packed {
        logic [2:0] func;
        logic       port;
        logic [7:0] data;
        logic [7:0] mask;
        logic       live;
        logic       typed;
        pio_res_t   exp;
    } pio_row_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [7:0] data_byte, [15:8] pin_mask
    logic [4:0]  s_tuser  = '0;    // [2:0] func, [3] port_sel, [4] pin_valid
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [7:0] read_data, [8] ack_valid, [16:9] ack_vector,
                                   // [17] out_valid, [25:18] drv_data, [33:26] out_changed,
                                   // [34] irq_line, [35] ready_a, [36] ready_b

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    parallel_io_controller_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // Controller image: per-port state as the block should hold it
    // ------------------------------------------------------------------
    pioc_pkg::mode_t pmode [2];
    logic [7:0] latch    [2];
    logic [7:0] pins     [2];
    logic       pfunc    [2];
    logic [7:0] pdir     [2];    // 1 = input bit in control mode
    logic [7:0] mask_n   [2];    // inverted mask byte
    logic       and_sel  [2];
    logic       hi_sel   [2];
    logic       mask_due [2];
    logic       dir_due  [2];
    logic [7:0] ivec     [2];
    logic       ien      [2];
    logic       isvc     [2];
    logic       ipend    [2];
    logic       rdy      [2];
    logic       first_wr [2];
    logic       irq_lvl;

    pio_res_t   res_q [$];       // results still owed by the block
    int         n_err    = 0;
    int         n_got    = 0;
    int         n_sent   = 0;
    int         idle_cyc = 0;
    bit         calm_tx  = 1'b0;
    logic       tx_typed = 1'b0; // set with each access, alongside s_tdata and s_tuser
    pio_res_t   tx_exp   = '0;

    // Strobe or trigger: only latched when the port has interrupts on
    function automatic void raise_irq(input logic p);
        if (ien[p]) begin
            ipend[p] = 1'b1;
            irq_lvl  = 1'b1;
        end
    endfunction

    // Data write to the output latch; input mode stores without driving
    function automatic void drive_latch(input logic p, input logic [7:0] v,
                                        inout pio_res_t r);
        logic [7:0] prev;
        if (pmode[p] == pioc_pkg::MODE_IN) begin
            latch[p] = v;
        end else begin
            prev        = first_wr[p] ? ~v : latch[p];   // first write: all bits change
            first_wr[p] = 1'b0;
            r.ov        = 1'b1;
            r.od        = v;
            r.oc        = prev ^ v;
            latch[p]    = v;
            rdy[p]      = 1'b1;
        end
    endfunction

    function automatic pio_res_t pio_predict(input logic [2:0] f, input logic p,
                                             input logic [7:0] d, input logic [7:0] mk,
                                             input logic live);
        pio_res_t        r;
        pioc_pkg::mode_t mode_was;
        logic            old_fn;
        logic            fn;
        logic [7:0]      s;
        r = '0;
        case (f)
            pioc_pkg::FUNC_READ: begin
                if (pmode[p] == pioc_pkg::MODE_CTL) begin
                    if (live)
                        pins[p] = d;
                    r.rd = (latch[p] & ~pdir[p]) | (pins[p] & pdir[p]);
                end else begin
                    r.rd = live ? d : latch[p];
                end
            end
            pioc_pkg::FUNC_WRITE: drive_latch(p, d, r);
            pioc_pkg::FUNC_CTRL: begin
                // follow-on bytes win over any decode
                if (dir_due[p]) begin
                    pdir[p]    = d;
                    dir_due[p] = 1'b0;
                end else if (mask_due[p]) begin
                    mask_n[p]   = ~d;
                    mask_due[p] = 1'b0;
                end else if (!d[0]) begin
                    ivec[p] = d;
                end else begin
                    case (d[3:0])
                        pioc_pkg::CTRL_IRQ_WORD: ien[p] = d[7];
                        pioc_pkg::CTRL_IRQ_CTRL: begin
                            ien[p]     = d[7];
                            and_sel[p] = d[6];
                            hi_sel[p]  = d[5];
                            if (d[4])
                                mask_due[p] = 1'b1;
                        end
                        pioc_pkg::CTRL_MODE: begin
                            mode_was = pmode[p];
                            pmode[p] = pioc_pkg::mode_t'(d[7:6]);
                            if (pmode[p] == pioc_pkg::MODE_CTL)
                                dir_due[p] = 1'b1;
                            if (mode_was == pioc_pkg::MODE_IN)
                                drive_latch(p, latch[p], r);
                        end
                        default: ;   // unknown odd byte: ignored
                    endcase
                end
            end
            pioc_pkg::FUNC_PIN: begin
                old_fn  = pfunc[p];
                pins[p] = (pins[p] & ~mk) | (d & mk);
                s       = pins[p] & mask_n[p];
                if (and_sel[p])
                    fn = hi_sel[p] ? (s == mask_n[p]) : (s == 8'h00);
                else
                    fn = hi_sel[p] ? (s != 8'h00) : (s != mask_n[p]);
                pfunc[p] = fn;
                if (!old_fn && fn)
                    raise_irq(p);
            end
            pioc_pkg::FUNC_STROBE: raise_irq(p);
            pioc_pkg::FUNC_ACK: begin
                // daisy chain: A first, B only when A is not in service
                if (ipend[0]) begin
                    ipend[0] = 1'b0;
                    isvc[0]  = 1'b1;
                    irq_lvl  = 1'b0;
                    r.ackv   = 1'b1;
                    r.vec    = ivec[0];
                end else if (!isvc[0] && ipend[1]) begin
                    ipend[1] = 1'b0;
                    isvc[1]  = 1'b1;
                    irq_lvl  = 1'b0;
                    r.ackv   = 1'b1;
                    r.vec    = ivec[1];
                end
            end
            pioc_pkg::FUNC_RETI: begin
                isvc[0] = 1'b0;
                isvc[1] = 1'b0;
                if (ipend[0])
                    raise_irq(1'b0);
                else if (ipend[1])
                    raise_irq(1'b1);
            end
            default: ;   // reserved function
        endcase
        r.irq = irq_lvl;
        r.ra  = rdy[0];
        r.rb  = rdy[1];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic log_miss(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        n_err++;
    endtask

    task automatic chk_field(input int idx, input string name,
                             input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            log_miss($sformatf("result %0d %s got %02h want %02h", idx, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Monitor: check output transfers, then predict input transfers
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        pio_res_t got;
        pio_res_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got.rd   = m_tdata[7:0];
                got.ackv = m_tdata[8];
                got.vec  = m_tdata[16:9];
                got.ov   = m_tdata[17];
                got.od   = m_tdata[25:18];
                got.oc   = m_tdata[33:26];
                got.irq  = m_tdata[34];
                got.ra   = m_tdata[35];
                got.rb   = m_tdata[36];
                if (res_q.size() == 0) begin
                    log_miss($sformatf("result %0d with nothing outstanding", n_got));
                end else begin
                    want = res_q.pop_front();
                    chk_field(n_got, "read_data",   got.rd,       want.rd);
                    chk_field(n_got, "ack_valid",   8'(got.ackv), 8'(want.ackv));
                    chk_field(n_got, "ack_vector",  got.vec,      want.vec);
                    chk_field(n_got, "out_valid",   8'(got.ov),   8'(want.ov));
                    chk_field(n_got, "drv_data",    got.od,       want.od);
                    chk_field(n_got, "out_changed", got.oc,       want.oc);
                    chk_field(n_got, "irq_line",    8'(got.irq),  8'(want.irq));
                    chk_field(n_got, "ready_a",     8'(got.ra),   8'(want.ra));
                    chk_field(n_got, "ready_b",     8'(got.rb),   8'(want.rb));
                end
                n_got++;
            end
            if (s_tvalid && s_tready) begin
                // image is always advanced; typed rows override the prediction
                want = pio_predict(s_tuser[2:0], s_tuser[3], s_tdata[7:0],
                                   s_tdata[15:8], s_tuser[4]);
                if (tx_typed)
                    want = tx_exp;
                res_q.push_back(want);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cyc = 0;
            else
                idle_cyc++;
        end
    end

    // Watchdog: a run that stops moving is a failure
    initial begin : watchdog
        while (idle_cyc < STALL_LIMIT)
            @(posedge clk);
        $display("FAIL parallel_io_controller_top");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random backpressure, a calm window, one long hold-off
    // ------------------------------------------------------------------
    initial begin : receiver
        int cyc;
        cyc = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN)
                m_tready <= 1'b0;
            else if (cyc >= CALM_RX_LO && cyc < CALM_RX_HI)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 16);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input logic [2:0] f, input logic p, input logic [7:0] d,
                        input logic [7:0] mk, input logic lv,
                        input logic ty, input pio_res_t ex);
        if (!calm_tx && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mk, d};
        s_tuser  <= {lv, p, f};
        tx_typed <= ty;
        tx_exp   <= ex;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic put(input logic [2:0] f, input logic p, input logic [7:0] d,
                       input logic [7:0] mk, input logic lv);
        send(f, p, d, mk, lv, 1'b0, '0);
    endtask

    // ready flags are never cleared, so hand-written results carry them high
    function automatic pio_res_t mk_res(input logic [7:0] rd, input logic ackv,
                                        input logic [7:0] vec, input logic ov,
                                        input logic [7:0] od, input logic [7:0] oc,
                                        input logic irq);
        pio_res_t r;
        r.rd   = rd;
        r.ackv = ackv;
        r.vec  = vec;
        r.ov   = ov;
        r.od   = od;
        r.oc   = oc;
        r.irq  = irq;
        r.ra   = 1'b1;
        r.rb   = 1'b1;
        return r;
    endfunction

    function automatic pio_row_t drow(input logic [2:0] f, input logic p,
                                      input logic [7:0] d, input logic [7:0] mk,
                                      input logic lv, input logic ty, input pio_res_t ex);
        pio_row_t r;
        r.func  = f;
        r.port  = p;
        r.data  = d;
        r.mask  = mk;
        r.live  = lv;
        r.typed = ty;
        r.exp   = ex;
        return r;
    endfunction

    pio_row_t dir_tab [N_DIR];

    initial begin : stim
        int         m;
        bit         paused;
        logic [2:0] f;
        logic       p;
        logic [7:0] b;
        logic [3:0] nib;
        pio_res_t   none;

        paused = 1'b0;
        none   = mk_res(8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);

        // image after reset: byte input, interrupts off, pins high
        pmode    = '{default: pioc_pkg::MODE_IN};
        latch    = '{default: 8'h00};
        pins     = '{default: 8'hff};
        pfunc    = '{default: 1'b0};
        pdir     = '{default: 8'h00};
        mask_n   = '{default: 8'hff};
        and_sel  = '{default: 1'b0};
        hi_sel   = '{default: 1'b0};
        mask_due = '{default: 1'b0};
        dir_due  = '{default: 1'b0};
        ivec     = '{default: 8'h00};
        ien      = '{default: 1'b0};
        isvc     = '{default: 1'b0};
        ipend    = '{default: 1'b0};
        rdy      = '{default: 1'b1};
        first_wr = '{default: 1'b1};
        irq_lvl  = 1'b0;

        // reads straight after reset, write stored in input mode
        dir_tab[0]  = drow(pioc_pkg::FUNC_READ,   PORT_A, 8'h00, 8'h00, 1'b0, 1'b1, none);
        dir_tab[1]  = drow(pioc_pkg::FUNC_READ,   PORT_B, 8'hff, 8'h00, 1'b1, 1'b1,
                           mk_res(8'hff, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0));
        dir_tab[2]  = drow(pioc_pkg::FUNC_WRITE,  PORT_A, 8'h5a, 8'h00, 1'b0, 1'b1, none);
        // input -> output: latch re-driven, first write flips every bit
        dir_tab[3]  = drow(pioc_pkg::FUNC_CTRL,   PORT_A, 8'h0f, 8'h00, 1'b0, 1'b1,
                           mk_res(8'h00, 1'b0, 8'h00, 1'b1, 8'h5a, 8'hff, 1'b0));
        dir_tab[4]  = drow(pioc_pkg::FUNC_WRITE,  PORT_A, 8'hff, 8'h00, 1'b0, 1'b0, none);
        // port B to control mode, direction byte follows
        dir_tab[5]  = drow(pioc_pkg::FUNC_CTRL,   PORT_B, 8'hcf, 8'h00, 1'b0, 1'b0, none);
        dir_tab[6]  = drow(pioc_pkg::FUNC_CTRL,   PORT_B, 8'hf0, 8'h00, 1'b0, 1'b0, none);
        dir_tab[7]  = drow(pioc_pkg::FUNC_PIN,    PORT_B, 8'ha5, 8'hff, 1'b0, 1'b0, none);
        dir_tab[8]  = drow(pioc_pkg::FUNC_READ,   PORT_B, 8'h3c, 8'h00, 1'b1, 1'b0, none);
        // port A: vector, interrupt control with mask byte, pin edge
        dir_tab[9]  = drow(pioc_pkg::FUNC_CTRL,   PORT_A, 8'h20, 8'h00, 1'b0, 1'b0, none);
        dir_tab[10] = drow(pioc_pkg::FUNC_CTRL,   PORT_A, 8'h97, 8'h00, 1'b0, 1'b0, none);
        dir_tab[11] = drow(pioc_pkg::FUNC_CTRL,   PORT_A, 8'hfe, 8'h00, 1'b0, 1'b0, none);
        dir_tab[12] = drow(pioc_pkg::FUNC_PIN,    PORT_A, 8'h00, 8'h01, 1'b0, 1'b0, none);
        dir_tab[13] = drow(pioc_pkg::FUNC_ACK,    PORT_B, 8'h00, 8'h00, 1'b0, 1'b1,
                           mk_res(8'h00, 1'b1, 8'h20, 1'b0, 8'h00, 8'h00, 1'b0));
        // ack with nothing pending
        dir_tab[14] = drow(pioc_pkg::FUNC_ACK,    PORT_A, 8'hff, 8'hff, 1'b1, 1'b1, none);
        dir_tab[15] = drow(pioc_pkg::FUNC_CTRL,   PORT_B, 8'h40, 8'h00, 1'b0, 1'b0, none);
        dir_tab[16] = drow(pioc_pkg::FUNC_CTRL,   PORT_B, 8'h83, 8'h00, 1'b0, 1'b0, none);
        dir_tab[17] = drow(pioc_pkg::FUNC_STROBE, PORT_B, 8'h00, 8'h00, 1'b0, 1'b0, none);
        // B pending but A still in service: not taken
        dir_tab[18] = drow(pioc_pkg::FUNC_ACK,    PORT_A, 8'h00, 8'h00, 1'b0, 1'b1,
                           mk_res(8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1));
        dir_tab[19] = drow(pioc_pkg::FUNC_RETI,   PORT_A, 8'h00, 8'h00, 1'b0, 1'b0, none);
        dir_tab[20] = drow(pioc_pkg::FUNC_ACK,    PORT_A, 8'h00, 8'h00, 1'b0, 1'b1,
                           mk_res(8'h00, 1'b1, 8'h40, 1'b0, 8'h00, 8'h00, 1'b0));
        // unknown odd control byte
        dir_tab[21] = drow(pioc_pkg::FUNC_CTRL,   PORT_A, 8'h05, 8'h00, 1'b0, 1'b1, none);
        // interrupts off, then a strobe does nothing
        dir_tab[22] = drow(pioc_pkg::FUNC_CTRL,   PORT_A, 8'h03, 8'h00, 1'b0, 1'b0, none);
        dir_tab[23] = drow(pioc_pkg::FUNC_STROBE, PORT_A, 8'h00, 8'h00, 1'b0, 1'b1, none);
        // output -> input, then input -> input: nothing driven either time
        dir_tab[24] = drow(pioc_pkg::FUNC_CTRL,   PORT_A, 8'h4f, 8'h00, 1'b0, 1'b1, none);
        dir_tab[25] = drow(pioc_pkg::FUNC_CTRL,   PORT_A, 8'h4f, 8'h00, 1'b0, 1'b1, none);
        // input -> bidirectional re-drives the latch
        dir_tab[26] = drow(pioc_pkg::FUNC_CTRL,   PORT_A, 8'h8f, 8'h00, 1'b0, 1'b0, none);
        dir_tab[27] = drow(FUNC_RSVD,             PORT_B, 8'hff, 8'hff, 1'b1, 1'b1, none);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[k])
            send(dir_tab[k].func, dir_tab[k].port, dir_tab[k].data, dir_tab[k].mask,
                 dir_tab[k].live, dir_tab[k].typed, dir_tab[k].exp);

        // random part: mostly well-formed setup and interrupt sequences
        while (n_sent < N_DIR + N_RAND) begin
            if (!paused && n_sent >= PAUSE_AT) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do @(negedge clk); while (res_q.size() != 0);
            end
            calm_tx = (n_sent >= CALM_TX_LO && n_sent < CALM_TX_HI);
            p = 1'($urandom);
            case ($urandom_range(9))
                0, 1: begin
                    f = ($urandom_range(31) == 0) ? FUNC_RSVD : 3'($urandom_range(6));
                    put(f, p, 8'($urandom), 8'($urandom), 1'($urandom));
                end
                2: begin
                    m = $urandom_range(3);
                    put(pioc_pkg::FUNC_CTRL, p, {2'(m), 2'($urandom), pioc_pkg::CTRL_MODE},
                        8'($urandom), 1'b0);
                    if (m == pioc_pkg::MODE_CTL)
                        put(pioc_pkg::FUNC_CTRL, p, 8'($urandom), 8'($urandom), 1'b0);
                    repeat ($urandom_range(1, 3))
                        put(pioc_pkg::FUNC_WRITE, p, 8'($urandom), 8'($urandom), 1'($urandom));
                    put(pioc_pkg::FUNC_READ, p, 8'($urandom), 8'($urandom), 1'($urandom));
                end
                3: begin
                    put(pioc_pkg::FUNC_CTRL, p, {7'($urandom), 1'b0}, 8'($urandom), 1'b0);
                    b = {($urandom_range(3) != 0), 3'($urandom), pioc_pkg::CTRL_IRQ_CTRL};
                    put(pioc_pkg::FUNC_CTRL, p, b, 8'($urandom), 1'b0);
                    if (b[4])
                        put(pioc_pkg::FUNC_CTRL, p, 8'($urandom), 8'($urandom), 1'b0);
                    repeat ($urandom_range(2, 6))
                        put(pioc_pkg::FUNC_PIN, p, 8'($urandom), 8'($urandom), 1'($urandom));
                    if ($urandom_range(1))
                        put(pioc_pkg::FUNC_ACK, 1'($urandom), 8'($urandom), 8'($urandom), 1'b0);
                    if ($urandom_range(1))
                        put(pioc_pkg::FUNC_RETI, 1'($urandom), 8'($urandom), 8'($urandom),
                            1'b0);
                end
                4: begin
                    b = {($urandom_range(3) != 0), 3'($urandom), pioc_pkg::CTRL_IRQ_WORD};
                    put(pioc_pkg::FUNC_CTRL, p, b, 8'($urandom), 1'($urandom));
                end
                5: begin
                    put(pioc_pkg::FUNC_STROBE, p, 8'($urandom), 8'($urandom), 1'($urandom));
                    if ($urandom_range(1))
                        put(pioc_pkg::FUNC_STROBE, ~p, 8'($urandom), 8'($urandom),
                            1'($urandom));
                    put(pioc_pkg::FUNC_ACK, 1'($urandom), 8'($urandom), 8'($urandom),
                        1'($urandom));
                    if ($urandom_range(3) != 0)
                        put(pioc_pkg::FUNC_RETI, 1'($urandom), 8'($urandom), 8'($urandom),
                            1'b0);
                end
                6: begin
                    repeat ($urandom_range(2, 5)) begin
                        f = $urandom_range(1) ? pioc_pkg::FUNC_WRITE : pioc_pkg::FUNC_READ;
                        put(f, p, 8'($urandom), 8'($urandom), 1'($urandom));
                    end
                end
                7: begin
                    f = $urandom_range(1) ? pioc_pkg::FUNC_ACK : pioc_pkg::FUNC_RETI;
                    put(f, p, 8'($urandom), 8'($urandom), 1'($urandom));
                end
                8: begin
                    repeat ($urandom_range(2, 6)) begin
                        f = ($urandom_range(4) == 0) ? pioc_pkg::FUNC_STROBE
                                                     : pioc_pkg::FUNC_PIN;
                        put(f, p, 8'($urandom), 8'($urandom), 1'($urandom));
                    end
                end
                default: begin
                    do nib = {3'($urandom), 1'b1};
                    while (nib == pioc_pkg::CTRL_IRQ_WORD || nib == pioc_pkg::CTRL_IRQ_CTRL ||
                           nib == pioc_pkg::CTRL_MODE);
                    put(pioc_pkg::FUNC_CTRL, p, {4'($urandom), nib}, 8'($urandom),
                        1'($urandom));
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // drain, then a few quiet cycles for anything stray
        while (res_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (res_q.size() != 0)
            log_miss($sformatf("%0d results never arrived", res_q.size()));

        if (n_err == 0)
            $display("PASS parallel_io_controller_top");
        else
            $display("FAIL parallel_io_controller_top");
        $finish;
    end

endmodule
